// ----- sv/shs_pkg.sv -----
// Shared types and constants for the SHA-256 stream hasher.
// No dependencies; the front end, back end, compression core and top level import this package.
package shs_pkg;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam int QDepth = 4;
  localparam int QAddrW = $clog2(QDepth);

  localparam logic [7:0] PadByte = 8'h80;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } item_t;

  // back end -> compression core
  typedef struct packed {
    logic        push;
    logic [31:0] word;
    logic        start;
    logic        init;
  } cmp_ctl_t;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ----- sv/shs_if.sv -----
// Stream interfaces for the SHA-256 hasher: message requests in, digest words out.
// Depends on nothing.
interface shs_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  modport source (output valid, cmd, data_byte, input ready);
  modport sink (input valid, cmd, data_byte, output ready);
endinterface

interface shs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- sv/shs_front.sv -----
// Front end: accepts message requests into a short queue for the back end.
// Depends on shs_pkg and shs_in_if.
module shs_front (
  input  logic          clk,
  input  logic          rst,
  shs_in_if.sink        msg,
  input  logic          pop,
  output logic          head_valid,
  output shs_pkg::item_t head
);
  import shs_pkg::*;

  item_t               q [QDepth];
  logic [QAddrW-1:0]   wptr;
  logic [QAddrW-1:0]   rptr;
  logic [QAddrW:0]     count;
  logic                push;
  logic                take;

  assign msg.ready  = (count != (QAddrW+1)'(QDepth));
  assign push       = msg.valid && msg.ready;
  assign head_valid = (count != '0);
  assign take       = pop && head_valid;
  assign head       = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= '{cmd: msg.cmd, data: msg.data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (take) rptr <= rptr + 1'b1;
      count <= count + (QAddrW+1)'(push) - (QAddrW+1)'(take);
    end
  end
endmodule

// ----- sv/shs_compress.sv -----
// SHA-256 compression core: 16-word schedule window, one round per cycle, chaining words.
// Depends on shs_pkg.
module shs_compress (
  input  logic               clk,
  input  logic               rst,
  input  shs_pkg::cmp_ctl_t  ctl,
  output logic               done,
  output logic [31:0]        hash [8]
);
  import shs_pkg::*;

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] h [8];
  logic        running;
  logic        fold;
  logic [5:0]  rnd;

  logic [31:0] w_new, s0, s1, t1, t2, bs1, bs0, ch, maj;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
    rotr = (x >> r) | (x << (32 - r));
  endfunction

  always_comb begin
    s0    = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1    = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    bs1   = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1    = v[7] + bs1 + ch + RoundK[rnd] + w[0];
    bs0   = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2    = bs0 + maj;
  end

  assign done = fold;
  assign hash = h;

  // schedule window: bytes shift in as words, then rounds slide it
  always_ff @(posedge clk) begin
    if (ctl.push || running) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= ctl.push ? ctl.word : w_new;
    end
    if (ctl.start) begin
      v <= h;
    end else if (running) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h       <= InitHash;
      running <= 1'b0;
      fold    <= 1'b0;
      rnd     <= '0;
    end else begin
      fold <= 1'b0;
      if (ctl.init) begin
        h <= InitHash;
      end else if (fold) begin
        for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
      end
      if (ctl.start) begin
        running <= 1'b1;
        rnd     <= '0;
      end else if (running) begin
        rnd <= rnd + 1'b1;
        if (rnd == 6'd63) begin
          running <= 1'b0;
          fold    <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- sv/shs_back.sv -----
// Back end: packs bytes into words, runs padding, sequences blocks, emits the digest.
// Depends on shs_pkg and shs_out_if.
module shs_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  shs_pkg::item_t     head,
  output logic               pop,
  output shs_pkg::cmp_ctl_t  ctl,
  input  logic               done,
  input  logic [31:0]        hash [8],
  shs_out_if.source          digest
);
  import shs_pkg::*;

  state_t      state, state_next;
  logic [5:0]  fill, fill_next;
  logic [23:0] acc, acc_next;
  logic [63:0] bitcnt, bitcnt_next;
  logic [63:0] len, len_next;
  logic        padding, padding_next;
  logic        pad_first, pad_first_next;
  logic        len_ok, len_ok_next;
  logic        final_blk, final_blk_next;
  logic [2:0]  eidx, eidx_next;
  logic        ovalid, ovalid_next;
  logic [31:0] oword, oword_next;
  logic [2:0]  oidx, oidx_next;
  logic        olast, olast_next;

  logic        put;
  logic [7:0]  pbyte;
  logic [63:0] len_sh;
  logic        oload;

  assign digest.valid       = ovalid;
  assign digest.digest_word = oword;
  assign digest.word_index  = oidx;
  assign digest.last_word   = olast;

  assign oload  = !ovalid || digest.ready;
  assign len_sh = len >> {~fill[2:0], 3'b000};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (head_valid) begin
          if (head.cmd == CMD_FINISH) state_next = ST_PAD;
          else if (fill == 6'd63) state_next = ST_ROUND;
        end
      end
      ST_PAD: begin
        if (fill == 6'd63) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (done) begin
          if (!padding) state_next = ST_IDLE;
          else if (final_blk) state_next = ST_EMIT;
          else state_next = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (oload && eidx == 3'd7) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop            = (state == ST_IDLE) && head_valid;
    put            = 1'b0;
    pbyte          = head.data;
    fill_next      = fill;
    acc_next       = acc;
    bitcnt_next    = bitcnt;
    len_next       = len;
    padding_next   = padding;
    pad_first_next = pad_first;
    len_ok_next    = len_ok;
    final_blk_next = final_blk;
    eidx_next      = eidx;
    ovalid_next    = ovalid && !digest.ready;
    oword_next     = oword;
    oidx_next      = oidx;
    olast_next     = olast;
    ctl            = '0;

    case (state)
      ST_IDLE: begin
        if (head_valid) begin
          if (head.cmd == CMD_ABSORB) begin
            put         = 1'b1;
            bitcnt_next = bitcnt + 64'd8;
          end else begin
            len_next       = bitcnt;
            padding_next   = 1'b1;
            pad_first_next = 1'b1;
          end
        end
      end
      ST_PAD: begin
        put            = 1'b1;
        pad_first_next = 1'b0;
        if (pad_first) begin
          pbyte       = PadByte;
          len_ok_next = (fill < 6'd56);
        end else if (len_ok && fill[5:3] == 3'd7) begin
          pbyte = len_sh[7:0];
        end else begin
          pbyte = 8'h00;
        end
        final_blk_next = len_ok && !pad_first;
      end
      ST_ROUND: begin
        // a padded block that was not final leaves the length for the next one
        if (done) len_ok_next = 1'b1;
      end
      ST_EMIT: begin
        if (oload) begin
          ovalid_next = 1'b1;
          oword_next  = hash[eidx];
          oidx_next   = eidx;
          olast_next  = (eidx == 3'd7);
          eidx_next   = eidx + 1'b1;
          if (eidx == 3'd7) begin
            ctl.init     = 1'b1;
            bitcnt_next  = '0;
            padding_next = 1'b0;
            len_ok_next  = 1'b0;
          end
        end
      end
      default: ;
    endcase

    if (put) begin
      fill_next = fill + 1'b1;
      acc_next  = {acc[15:0], pbyte};
      ctl.push  = (fill[1:0] == 2'd3);
      ctl.word  = {acc, pbyte};
      ctl.start = (fill == 6'd63);
    end
  end

  always_ff @(posedge clk) begin
    acc   <= acc_next;
    len   <= len_next;
    oword <= oword_next;
    oidx  <= oidx_next;
    olast <= olast_next;
    final_blk <= final_blk_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      bitcnt    <= '0;
      padding   <= 1'b0;
      pad_first <= 1'b0;
      len_ok    <= 1'b0;
      eidx      <= '0;
      ovalid    <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      bitcnt    <= bitcnt_next;
      padding   <= padding_next;
      pad_first <= pad_first_next;
      len_ok    <= len_ok_next;
      eidx      <= eidx_next;
      ovalid    <= ovalid_next;
    end
  end
endmodule

// ----- sv/sha256_stream_hasher_unit.sv -----
// SHA-256 stream hasher top level: front queue, back-end sequencer, compression core.
// Depends on shs_pkg, shs_if, shs_front, shs_back, shs_compress.
//
//   channel  dir  payload                                 one request
//   msg      in   cmd, data_byte                          absorb a byte or finish
//   digest   out  digest_word, word_index, last_word      one digest word
//
// An absorb is handled in the back end's idle state; the 64th byte of a block
// starts the 64 rounds and the fold. Finish runs padding one byte per cycle through
// the same path, one or two blocks, then eight words leave through the output
// register. The four-entry queue keeps taking requests while the core runs, until it is full.
// Reset is synchronous; it loads the initial chaining words and clears the count.
module sha256_stream_hasher_unit (
  input  logic       clk,
  input  logic       rst,
  shs_in_if.sink     msg,
  shs_out_if.source  digest
);
  import shs_pkg::*;

  logic        head_valid;
  item_t       head;
  logic        pop;
  cmp_ctl_t    ctl;
  logic        done;
  logic [31:0] hash [8];

  shs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .msg        (msg),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  shs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .ctl        (ctl),
    .done       (done),
    .hash       (hash),
    .digest     (digest)
  );

  shs_compress u_compress (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .done (done),
    .hash (hash)
  );
endmodule
